FILE: hw/rtl/lbpsh_pkg.sv
package lbpsh_pkg;

	// default sizes
	localparam int MAX_CELLS    = 64;
	localparam int MAX_PATTERNS = 256;
	localparam int IMAGE_MAX    = 512;

	// field widths
	localparam int CNT_W  = 19;
	localparam int CT_W   = 7;
	localparam int CODE_W = 8;
	localparam int BIDX_W = 14;
	localparam int REQ_W  = 2;
	localparam int STAT_W = 2;

	// stream widths
	localparam int IN_DW  = 24;
	localparam int OUT_DW = 32;

	// configuration port
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 10;

	localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_CELL_WIDTH    = 3'd2;
	localparam logic [CFG_IW-1:0] REG_CELL_HEIGHT   = 3'd3;
	localparam logic [CFG_IW-1:0] REG_OVERLAP       = 3'd4;
	localparam logic [CFG_IW-1:0] REG_PATTERN_COUNT = 3'd5;

	localparam logic [9:0] RST_IMAGE_WIDTH   = 10'd512;
	localparam logic [9:0] RST_IMAGE_HEIGHT  = 10'd512;
	localparam logic [9:0] RST_CELL_WIDTH    = 10'd64;
	localparam logic [9:0] RST_CELL_HEIGHT   = 10'd64;
	localparam logic [8:0] RST_OVERLAP       = 9'd0;
	localparam logic [8:0] RST_PATTERN_COUNT = 9'd256;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// result status
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_CODE   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BEYOND = 2'd3;

endpackage

FILE: hw/rtl/lbpsh_ram.sv
module lbpsh_ram #(
	parameter int WIDTH = lbpsh_pkg::CNT_W,
	parameter int DEPTH = lbpsh_pkg::MAX_CELLS * lbpsh_pkg::MAX_PATTERNS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/lbp_spatial_histogram.sv
// channel   dir  handshake                 payload
// s         in   s_tvalid / s_tready       s_tuser: req_type, s_tdata: pixel_code, bin_index
// m         out  m_tvalid / m_tready       m_tuser: status, m_tdata: bin_count, cell_total
// cfg       in   cfg_valid / cfg_ready     cfg_index: register, cfg_data: value
//
// pixel request: the covered cells kept in the store (at most MAX_CELLS) are taken one by one;
//   one read-modify-write of the bin memory per covered cell, through its single read port;
//   a too large code or no cells skips the cell run, and once all rows are taken the position holds
// read request: one registered read of the bin memory; unknown request: straight to the result
// clear request and reset: clearing pass over all MAX_CELLS*MAX_PATTERNS bins (16384 by default),
//   then a geometry rebuild; a config write also triggers the rebuild
// a finished result waits in the output register while the next request is taken
module lbp_spatial_histogram #(
	parameter int MAX_CELLS    = lbpsh_pkg::MAX_CELLS,
	parameter int MAX_PATTERNS = lbpsh_pkg::MAX_PATTERNS,
	parameter int IMAGE_MAX    = lbpsh_pkg::IMAGE_MAX
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lbpsh_pkg::IN_DW-1:0]     s_tdata,   // pixel_code[7:0], bin_index[21:8]
	input  logic [lbpsh_pkg::REQ_W-1:0]     s_tuser,   // req_type[1:0]
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lbpsh_pkg::OUT_DW-1:0]    m_tdata,   // bin_count[18:0], cell_total[25:19]
	output logic [lbpsh_pkg::STAT_W-1:0]    m_tuser,   // status[1:0]
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lbpsh_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [lbpsh_pkg::CFG_DW-1:0]    cfg_data
);

	// dimension width: holds image sizes up to IMAGE_MAX and 10 bit cell sizes
	localparam int DW    = ($clog2(IMAGE_MAX + 1) > 10) ? $clog2(IMAGE_MAX + 1) : 10;
	localparam int RBW   = 2 * DW;
	localparam int STORE = MAX_CELLS * MAX_PATTERNS;
	localparam int AW    = $clog2(STORE);
	localparam int CLW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int TW    = $clog2(MAX_CELLS + 1);
	localparam int LW    = TW + 9;
	localparam int CNT_W = lbpsh_pkg::CNT_W;

	localparam logic [3:0] ST_SWEEP = 4'd0;
	localparam logic [3:0] ST_WINIT = 4'd1;
	localparam logic [3:0] ST_WALK  = 4'd2;
	localparam logic [3:0] ST_WFIN1 = 4'd3;
	localparam logic [3:0] ST_WFIN2 = 4'd4;
	localparam logic [3:0] ST_IDLE  = 4'd5;
	localparam logic [3:0] ST_PSET  = 4'd6;
	localparam logic [3:0] ST_PRUN  = 4'd7;
	localparam logic [3:0] ST_PADV  = 4'd8;
	localparam logic [3:0] ST_RDRES = 4'd9;
	localparam logic [3:0] ST_DONE  = 4'd10;

	// per axis tracking: hi = pos/step, lo = first cell still covering pos
	typedef struct packed {
		logic [DW-1:0] hi;
		logic [DW-1:0] hr;
		logic [DW-1:0] lo;
		logic [DW-1:0] lr;
	} axis_t;

	// move axis tracking from pos to pos+1
	function automatic axis_t ax_step(input axis_t a, input logic [DW-1:0] pos,
			input logic [DW-1:0] s, input logic [DW-1:0] c);
		axis_t      n;
		logic [DW:0] nxt;
		n   = a;
		nxt = {1'b0, pos} + 1'b1;
		if ((a.hr + 1'b1) == s) begin
			n.hi = a.hi + 1'b1;
			n.hr = '0;
		end else begin
			n.hr = a.hr + 1'b1;
		end
		if (nxt == {1'b0, c}) begin
			n.lo = DW'(1);
			n.lr = '0;
		end else if (pos >= c) begin
			if ((a.lr + 1'b1) == s) begin
				n.lo = a.lo + 1'b1;
				n.lr = '0;
			end else begin
				n.lr = a.lr + 1'b1;
			end
		end
		return n;
	endfunction

	// configuration registers
	logic [9:0] cfg_w_q, cfg_h_q, cfg_cw_q, cfg_ch_q;
	logic [8:0] cfg_ov_q, cfg_pc_q;
	logic       dirty_q;

	// control
	logic [3:0]    state_q;
	logic [AW-1:0] sw_q;
	logic [DW-1:0] wt_q;
	logic          res_pend_q;

	// position and derived geometry
	logic [DW-1:0] col_q, row_q;
	axis_t         xa_q, ya_q;
	logic [DW-1:0] nx_q, ny_q;
	logic [DW:0]   accx_q, accy_q;
	logic [RBW-1:0] prod_q;
	logic [TW-1:0] total_q;
	logic [LW-1:0] lim_q;

	// pixel iteration
	logic [lbpsh_pkg::CODE_W-1:0] code_q;
	logic [DW-1:0]  kx_q, ky_q, ylo_q, xmax_q, ymax_q;
	logic           yok_q;
	logic [RBW-1:0] rowbase_q;
	logic           v_s1;
	logic [AW-1:0]  addr_s1;

	// result
	logic [CNT_W-1:0]              res_cnt_q;
	logic [lbpsh_pkg::STAT_W-1:0]  res_st_q;
	logic                          rd_ok_q;
	logic                          m_tvalid_q;
	logic [CNT_W-1:0]              m_cnt_q;
	logic [lbpsh_pkg::STAT_W-1:0]  m_st_q;
	logic [lbpsh_pkg::CT_W-1:0]    m_tot_q;

	// combinational
	logic [DW-1:0] w_c, h_c, cw_c, ch_c, ov_c, sx_c, sy_c, xlim_c, ylim_c;
	logic [DW-1:0] xmax_c, ymax_c;
	logic [8:0]    pc_c;
	logic [TW-1:0] total_c;
	logic [RBW:0]  cell_c;
	logic          run_ok_c;
	logic [CLW-1:0] cell_lo_c;
	logic [AW-1:0] addr_c;
	logic          in_fire, cfg_fire;
	logic [lbpsh_pkg::REQ_W-1:0]  req_c;
	logic [lbpsh_pkg::CODE_W-1:0] code_c;
	logic [lbpsh_pkg::BIDX_W-1:0] bidx_c;
	logic          rng_ok_c;
	logic          rd_en_c;
	logic [AW-1:0] rd_addr_c;
	logic [CNT_W-1:0] rdata;
	logic          we_c;
	logic [AW-1:0] waddr_c;
	logic [CNT_W-1:0] wdata_c;

	assign req_c    = s_tuser;
	assign code_c   = s_tdata[7:0];
	assign bidx_c   = s_tdata[21:8];
	assign s_tready = (state_q == ST_IDLE) && !dirty_q;
	assign in_fire  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_st_q;
	assign m_tdata  = {{(lbpsh_pkg::OUT_DW - CNT_W - lbpsh_pkg::CT_W){1'b0}}, m_tot_q, m_cnt_q};

	// effective geometry: sizes clamped, step falls back to 1 with large overlap
	always_comb begin
		w_c  = (cfg_w_q == '0) ? DW'(1) :
		       ((DW'(cfg_w_q) > DW'(IMAGE_MAX)) ? DW'(IMAGE_MAX) : DW'(cfg_w_q));
		h_c  = (cfg_h_q == '0) ? DW'(1) :
		       ((DW'(cfg_h_q) > DW'(IMAGE_MAX)) ? DW'(IMAGE_MAX) : DW'(cfg_h_q));
		cw_c = (cfg_cw_q == '0) ? DW'(1) : DW'(cfg_cw_q);
		ch_c = (cfg_ch_q == '0) ? DW'(1) : DW'(cfg_ch_q);
		ov_c = DW'(cfg_ov_q);
		sx_c = (ov_c < cw_c) ? (cw_c - ov_c) : DW'(1);
		sy_c = (ov_c < ch_c) ? (ch_c - ov_c) : DW'(1);
		xlim_c = w_c - cw_c;
		ylim_c = h_c - ch_c;
		pc_c = (cfg_pc_q > 9'(MAX_PATTERNS)) ? 9'(MAX_PATTERNS) : cfg_pc_q;
		total_c = (prod_q > RBW'(MAX_CELLS)) ? TW'(MAX_CELLS) : TW'(prod_q);
		xmax_c = (xa_q.hi > (nx_q - 1'b1)) ? (nx_q - 1'b1) : xa_q.hi;
		ymax_c = (ya_q.hi > (ny_q - 1'b1)) ? (ny_q - 1'b1) : ya_q.hi;
	end

	// current cell of the iteration and its bin address
	always_comb begin
		cell_c    = {1'b0, rowbase_q} + (RBW + 1)'(ky_q);
		run_ok_c  = yok_q && (kx_q <= xmax_q) && (cell_c < (RBW + 1)'(MAX_CELLS));
		cell_lo_c = cell_c[CLW-1:0];
		addr_c    = AW'(cell_lo_c) * AW'(pc_c) + AW'(code_q);
		rng_ok_c  = (32'(bidx_c) < 32'(lim_q)) && (32'(bidx_c) < 32'(STORE));
	end

	// memory ports: read for iteration or bin read, write for clearing pass or update
	always_comb begin
		if (state_q == ST_PRUN) begin
			rd_en_c   = run_ok_c;
			rd_addr_c = addr_c;
		end else begin
			rd_en_c   = in_fire && (req_c == lbpsh_pkg::REQ_READ) && rng_ok_c;
			rd_addr_c = AW'(bidx_c);
		end
		if (state_q == ST_SWEEP) begin
			we_c    = 1'b1;
			waddr_c = sw_q;
			wdata_c = '0;
		end else begin
			we_c    = v_s1;
			waddr_c = addr_s1;
			// counters saturate
			wdata_c = (rdata == '1) ? rdata : (rdata + 1'b1);
		end
	end

	lbpsh_ram #(
		.WIDTH (CNT_W),
		.DEPTH (STORE)
	) u_bins (
		.clk   (clk),
		.we    (we_c),
		.waddr (waddr_c),
		.wdata (wdata_c),
		.re    (rd_en_c),
		.raddr (rd_addr_c),
		.rdata (rdata)
	);

	// configuration registers; any write forces a geometry rebuild
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q  <= lbpsh_pkg::RST_IMAGE_WIDTH;
			cfg_h_q  <= lbpsh_pkg::RST_IMAGE_HEIGHT;
			cfg_cw_q <= lbpsh_pkg::RST_CELL_WIDTH;
			cfg_ch_q <= lbpsh_pkg::RST_CELL_HEIGHT;
			cfg_ov_q <= lbpsh_pkg::RST_OVERLAP;
			cfg_pc_q <= lbpsh_pkg::RST_PATTERN_COUNT;
			dirty_q  <= 1'b0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					lbpsh_pkg::REG_IMAGE_WIDTH:   cfg_w_q  <= cfg_data;
					lbpsh_pkg::REG_IMAGE_HEIGHT:  cfg_h_q  <= cfg_data;
					lbpsh_pkg::REG_CELL_WIDTH:    cfg_cw_q <= cfg_data;
					lbpsh_pkg::REG_CELL_HEIGHT:   cfg_ch_q <= cfg_data;
					lbpsh_pkg::REG_OVERLAP:       cfg_ov_q <= cfg_data[8:0];
					lbpsh_pkg::REG_PATTERN_COUNT: cfg_pc_q <= cfg_data[8:0];
					default: ;
				endcase
				dirty_q <= 1'b1;
			end else if (state_q == ST_WINIT) begin
				dirty_q <= 1'b0;
			end
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			sw_q       <= '0;
			res_pend_q <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			v_s1       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			v_s1    <= (state_q == ST_PRUN) && run_ok_c;
			addr_s1 <= addr_c;

			// output register empties when taken, unless refilled below
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_SWEEP: begin
					if (sw_q == AW'(STORE - 1)) begin
						sw_q    <= '0;
						state_q <= ST_WINIT;
					end else begin
						sw_q <= sw_q + 1'b1;
					end
				end
				ST_WINIT: begin
					wt_q    <= '0;
					xa_q    <= '0;
					ya_q    <= '0;
					nx_q    <= '0;
					ny_q    <= '0;
					accx_q  <= '0;
					accy_q  <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					// walk axis tracking up to the current position
					if (wt_q < col_q) begin
						xa_q <= ax_step(xa_q, wt_q, sx_c, cw_c);
					end
					if (wt_q < row_q) begin
						ya_q <= ax_step(ya_q, wt_q, sy_c, ch_c);
					end
					// count cell starts below size - cell
					if ((w_c > cw_c) && (accx_q < {1'b0, xlim_c})) begin
						nx_q   <= nx_q + 1'b1;
						accx_q <= accx_q + {1'b0, sx_c};
					end
					if ((h_c > ch_c) && (accy_q < {1'b0, ylim_c})) begin
						ny_q   <= ny_q + 1'b1;
						accy_q <= accy_q + {1'b0, sy_c};
					end
					if (wt_q == DW'(IMAGE_MAX)) begin
						state_q <= ST_WFIN1;
					end else begin
						wt_q <= wt_q + 1'b1;
					end
				end
				ST_WFIN1: begin
					prod_q  <= RBW'(nx_q) * RBW'(ny_q);
					state_q <= ST_WFIN2;
				end
				ST_WFIN2: begin
					total_q <= total_c;
					lim_q   <= LW'(total_c) * LW'(pc_c);
					if (dirty_q) begin
						state_q <= ST_WINIT;
					end else if (res_pend_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (dirty_q) begin
						state_q <= ST_WINIT;
					end else if (in_fire) begin
						res_cnt_q <= '0;
						res_st_q  <= ((req_c == lbpsh_pkg::REQ_READ) && !rng_ok_c) ?
						             lbpsh_pkg::STAT_RANGE : lbpsh_pkg::STAT_OK;
						code_q    <= code_c;
						rd_ok_q   <= rng_ok_c;
						case (req_c)
							lbpsh_pkg::REQ_PIXEL: begin
								// column left past a lowered row end: go to next row
								if (col_q >= w_c) begin
									col_q <= '0;
									xa_q  <= '0;
									if (row_q < h_c) begin
										row_q <= row_q + 1'b1;
										ya_q  <= ax_step(ya_q, row_q, sy_c, ch_c);
									end
								end
								state_q <= ST_PSET;
							end
							lbpsh_pkg::REQ_READ: begin
								state_q <= ST_RDRES;
							end
							lbpsh_pkg::REQ_CLEAR: begin
								col_q      <= '0;
								row_q      <= '0;
								sw_q       <= '0;
								res_pend_q <= 1'b1;
								state_q    <= ST_SWEEP;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_PSET: begin
					if (row_q >= h_c) begin
						// all rows taken, position holds
						res_st_q <= lbpsh_pkg::STAT_BEYOND;
						state_q  <= ST_DONE;
					end else if ({1'b0, code_q} >= pc_c) begin
						res_st_q <= lbpsh_pkg::STAT_CODE;
						state_q  <= ST_PADV;
					end else if ((nx_q == '0) || (ny_q == '0)) begin
						state_q <= ST_PADV;
					end else begin
						xmax_q    <= xmax_c;
						ymax_q    <= ymax_c;
						yok_q     <= (ya_q.lo <= ymax_c);
						kx_q      <= xa_q.lo;
						ky_q      <= ya_q.lo;
						ylo_q     <= ya_q.lo;
						rowbase_q <= RBW'(xa_q.lo) * RBW'(ny_q);
						state_q   <= ST_PRUN;
					end
				end
				ST_PRUN: begin
					// one covered cell per cycle, x outer and y inner
					if (run_ok_c) begin
						if (ky_q == ymax_q) begin
							ky_q      <= ylo_q;
							kx_q      <= kx_q + 1'b1;
							rowbase_q <= rowbase_q + RBW'(ny_q);
						end else begin
							ky_q <= ky_q + 1'b1;
						end
					end else begin
						state_q <= ST_PADV;
					end
				end
				ST_PADV: begin
					// last update is already written by the final PRUN cycle; step to next pixel
					if (({1'b0, col_q} + 1'b1) >= {1'b0, w_c}) begin
						col_q <= '0;
						xa_q  <= '0;
						row_q <= row_q + 1'b1;
						ya_q  <= ax_step(ya_q, row_q, sy_c, ch_c);
					end else begin
						col_q <= col_q + 1'b1;
						xa_q  <= ax_step(xa_q, col_q, sx_c, cw_c);
					end
					state_q <= ST_DONE;
				end
				ST_RDRES: begin
					res_cnt_q <= rd_ok_q ? rdata : '0;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_cnt_q    <= res_cnt_q;
						m_st_q     <= res_st_q;
						m_tot_q    <= lbpsh_pkg::CT_W'(total_q);
						m_tvalid_q <= 1'b1;
						res_pend_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
